>>> rtl/core/dbm_pkg.sv
package dbm_pkg;

  localparam int MaxEntries  = 64;
  localparam int MaxNameLen  = 255;
  localparam int EntW        = $clog2(MaxEntries);
  localparam int CntW        = EntW + 1;
  localparam int MaxPatLen   = 255;

  localparam logic [7:0] ChStar = 8'h2A;
  localparam logic [7:0] ChDot  = 8'h2E;
  localparam logic [7:0] ChHash = 8'h23;

  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdQuery = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;
  localparam logic [1:0] CmdSpare = 2'd3;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StLong = 2'd2;
  localparam logic [1:0] StSkip = 2'd3;

  // One name byte, counted from the end of the trimmed name, broadcast to the cells.
  typedef struct packed {
    logic       start;   // first byte of a new comparison pass
    logic       vld;     // a byte is presented
    logic [7:0] ch;      // name byte at tail offset pos
    logic [7:0] pos;     // offset from the end: 0 is the last byte
    logic       dot_prev;// the byte before ch is a dot and is not the first byte
    logic       is_first;// ch is the name's first byte
  } dbm_bcast_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/dbm_cell.sv
module dbm_cell
  import dbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic       len_en,
  input  logic [7:0] len_val,
  input  logic       active,
  input  dbm_bcast_t bc,
  output logic       hit
);

  // One table entry: its bytes in a small memory, read back from its tail
  // in step with the name bytes of the broadcast.
  logic [7:0] mem [0:255];
  logic [7:0] len_r;
  logic [7:0] rd_r;
  logic       star_r;
  logic       eq_r, eq_nxt;       // tail so far matches
  logic       hit_r, hit_nxt;
  logic       bc_vld_r;
  logic [7:0] bc_ch_r, bc_pos_r;
  logic       bc_dot_r, bc_first_r, bc_start_r;
  logic [7:0] rd_addr;
  logic [7:0] plen;   // compared length: length minus one for a star entry
  logic       in_rng;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
    if (len_en) begin
      len_r <= len_val;
    end
    if (wr_en && wr_addr == 8'd0) begin
      star_r <= (wr_data == ChStar);
    end
  end

  assign plen    = star_r ? len_r - 8'd1 : len_r;
  assign rd_addr = len_r - 8'd1 - bc.pos;

  always_comb begin
    eq_nxt  = bc_start_r ? 1'b1 : eq_r;
    hit_nxt = bc_start_r ? 1'b0 : hit_r;
    in_rng  = (bc_pos_r < plen);
    // A bare star entry matches every name, the empty one included.
    if (bc_start_r && star_r && plen == 8'd0) begin
      hit_nxt = 1'b1;
    end
    if (bc_vld_r) begin
      if (in_rng) begin
        eq_nxt = eq_nxt && (rd_r == bc_ch_r);
      end
      // The last byte of the compared tail is reached with every byte equal.
      // A star entry matches here; a plain one needs the whole name or a dot
      // in front of the tail that is not the name's first byte.
      if (plen != 8'd0 && bc_pos_r == plen - 8'd1 && eq_nxt) begin
        if (star_r || bc_first_r || bc_dot_r) begin
          hit_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bc_ch_r    <= bc.ch;
    bc_pos_r   <= bc.pos;
    bc_dot_r   <= bc.dot_prev;
    bc_first_r <= bc.is_first;
    eq_r       <= eq_nxt;
    if (!rst_n) begin
      bc_vld_r   <= 1'b0;
      bc_start_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      bc_vld_r   <= bc.vld;
      bc_start_r <= bc.start;
      hit_r      <= hit_nxt;
    end
  end

  assign hit = hit_r && active;

endmodule

>>> rtl/core/domain_blocklist_matcher.sv
// Channel | Handshake              | Beat contents
// input   | in_tvalid, in_tready   | tdata: char_byte, has_byte; tuser: command; tlast: last
// output  | out_tvalid, out_tready | tdata: blocked, match_index, status, was_query
//
// Byte beats without tlast are taken one per cycle while no answer waits. A
// load beat with tlast, or any clear beat, has its answer in the output
// register in the next cycle. A query beat with tlast starts a pass, unless
// the name was too long, that walks the trimmed name from its last byte to
// its first through a broadcast to every entry cell, then drains the cell
// pipeline, then scans the entries one per cycle for the lowest hit.
// Reset is synchronous and active low; table contents need no clearing since
// the entry count gates every cell. The input is held off during a pass and
// while an answer waits for out_tready.
module domain_blocklist_matcher
  import dbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] char_byte, [8] has_byte, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] blocked, [6:1] match_index,
                                  // [8:7] status, [9] was_query, rest zero
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_PICK} state_t;

  state_t      state_r;
  logic [CntW-1:0] count_r;
  logic [8:0]  nlen_r, llen_r;
  logic        ovf_r;
  logic [7:0]  first_r;        // first pattern byte of the entry being loaded
  logic [7:0]  nbuf [0:255];
  logic [7:0]  nb_rd_r;
  logic [7:0]  dlen_r;
  logic [8:0]  step_r;
  logic [2:0]  drain_r;
  logic [EntW-1:0] scan_r;
  logic        out_v_r;
  logic [15:0] out_d_r;
  logic        last_dot_r;

  logic [1:0]  cmd;
  logic [7:0]  ch;
  logic        has, acc;
  assign cmd = in_tuser;
  assign ch  = fold_case(in_tdata[7:0]);
  assign has = in_tdata[8];
  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // Name buffer: bytes are read from the tail, one per cycle, during a walk.
  logic [7:0] nb_raddr;
  logic [7:0] nb_prev_r;  // not driven; the byte in front of the current one is read into prev_byte_rd
  logic       walk_v_r, walk_start_r;
  logic [7:0] walk_pos_r;
  logic [7:0] prev_byte_rd;
  assign nb_raddr = dlen_r - 8'd1 - step_r[7:0];

  always_ff @(posedge clk) begin
    if (acc && cmd == CmdQuery && has && nlen_r < 9'(MaxNameLen)) begin
      nbuf[nlen_r[7:0]] <= ch;
    end
    nb_rd_r      <= nbuf[nb_raddr];
    prev_byte_rd <= nbuf[nb_raddr - 8'd1];
  end

  // Broadcast: byte at tail offset pos plus the byte in front of it.
  dbm_bcast_t bc;
  always_comb begin
    bc.start    = walk_start_r;
    bc.vld      = walk_v_r;
    bc.ch       = nb_rd_r;
    bc.pos      = walk_pos_r;
    bc.is_first = walk_v_r && (walk_pos_r == dlen_r - 8'd1);
    bc.dot_prev = (prev_byte_rd == ChDot) &&
                  ({1'b0, walk_pos_r} + 9'd2 < {1'b0, dlen_r});
  end

  // Load path toward the cells.
  logic        ld_wr;
  logic        ld_end;
  logic        full;
  assign full  = count_r >= CntW'(MaxEntries);
  assign ld_wr = acc && cmd == CmdLoad && has && llen_r < 9'(MaxPatLen) && !full;
  logic        commit;
  assign commit = acc && cmd == CmdLoad && in_tlast && !full &&
                  !(ovf_r || (has && llen_r >= 9'(MaxPatLen))) &&
                  !((llen_r == 9'd0 && !has) ||
                    (llen_r == 9'd0 ? ch == ChHash : first_r == ChHash));

  logic [MaxEntries-1:0] hits;
  genvar g;
  generate
    for (g = 0; g < MaxEntries; g++) begin : g_cell
      dbm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ld_wr && count_r[EntW-1:0] == EntW'(g)),
        .wr_addr (llen_r[7:0]),
        .wr_data (ch),
        .len_en  (commit && count_r[EntW-1:0] == EntW'(g)),
        .len_val (llen_r[7:0] + (has ? 8'd1 : 8'd0)),
        .active  (count_r > CntW'(g)),
        .bc      (bc),
        .hit     (hits[g])
      );
    end
  endgenerate

  logic [1:0] ld_status;
  always_comb begin
    if (full) begin
      ld_status = StFull;
    end else if (ovf_r || (has && llen_r >= 9'(MaxPatLen))) begin
      ld_status = StLong;
    end else if (!commit) begin
      ld_status = StSkip;
    end else begin
      ld_status = StOk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      nlen_r       <= '0;
      llen_r       <= '0;
      ovf_r        <= 1'b0;
      out_v_r      <= 1'b0;
      walk_v_r     <= 1'b0;
      walk_start_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      // the first step of a walk opens a new comparison pass in the cells
      walk_start_r <= (state_r == S_WALK) && (step_r == 9'd0);
      case (state_r)
        S_IDLE: begin
          walk_v_r <= 1'b0;
          if (acc) begin
            case (cmd)
              CmdClear: begin
                count_r <= '0;
                nlen_r  <= '0;
                llen_r  <= '0;
                ovf_r   <= 1'b0;
                out_v_r <= 1'b1;
                out_d_r <= '0;
              end
              CmdLoad: begin
                if (in_tlast) begin
                  if (commit) begin
                    count_r <= count_r + CntW'(1);
                  end
                  llen_r  <= '0;
                  ovf_r   <= 1'b0;
                  out_v_r <= 1'b1;
                  out_d_r <= {6'd0, 1'b0, ld_status, 6'd0, 1'b0};
                end else if (has) begin
                  if (llen_r < 9'(MaxPatLen)) begin
                    llen_r <= llen_r + 9'd1;
                    if (llen_r == 9'd0) begin
                      first_r <= ch;
                    end
                  end else begin
                    ovf_r <= 1'b1;
                  end
                end
              end
              CmdQuery: begin
                logic [8:0] nl;
                logic       ov;
                nl = nlen_r;
                ov = ovf_r;
                if (has) begin
                  if (nlen_r < 9'(MaxNameLen)) begin
                    nl = nlen_r + 9'd1;
                  end else begin
                    ov = 1'b1;
                  end
                end
                if (in_tlast) begin
                  nlen_r <= '0;
                  ovf_r  <= 1'b0;
                  if (ov) begin
                    out_v_r <= 1'b1;
                    out_d_r <= {6'd0, 1'b1, StLong, 6'd0, 1'b0};
                  end else begin
                    // trailing dot removal: the tail byte is this beat's byte if it has
                    // one, else the last stored byte, tracked by last_dot_r
                    if (nl != 9'd0 && ((has && ch == ChDot) ||
                        (!has && last_dot_r))) begin
                      dlen_r <= nl[7:0] - 8'd1;
                    end else begin
                      dlen_r <= nl[7:0];
                    end
                    step_r  <= '0;
                    state_r <= S_WALK;
                  end
                end else begin
                  nlen_r <= nl;
                  ovf_r  <= ov;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          // memory read address presented now; byte valid next cycle
          walk_v_r   <= (step_r[7:0] < dlen_r);
          walk_pos_r <= step_r[7:0];
          step_r <= step_r + 9'd1;
          if (step_r >= {1'b0, dlen_r}) begin
            drain_r <= 3'd0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          walk_v_r <= 1'b0;
          drain_r  <= drain_r + 3'd1;
          if (drain_r == 3'd3) begin
            scan_r  <= '0;
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          // priority pick of the lowest hitting entry, one entry per cycle
          if (hits[scan_r]) begin
            out_v_r <= 1'b1;
            out_d_r <= {6'd0, 1'b1, StOk, 6'(scan_r), 1'b1};
            state_r <= S_IDLE;
          end else if (scan_r == EntW'(MaxEntries - 1)) begin
            out_v_r <= 1'b1;
            out_d_r <= {6'd0, 1'b1, StOk, 6'd0, 1'b0};
            state_r <= S_IDLE;
          end else begin
            scan_r <= scan_r + EntW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Tracks whether the most recently stored name byte is a dot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dot_r <= 1'b0;
    end else if (acc && cmd == CmdQuery && has && nlen_r < 9'(MaxNameLen)) begin
      last_dot_r <= (ch == ChDot);
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

// Blocklist oracle: keeps a shadow copy of the pattern table and name buffer,
// and queues the answer the block must give for each accepted beat that calls for one.
class blocklist_oracle;
  logic [7:0]  pat_mem [64][256];
  logic [7:0]  pat_len [64];
  int unsigned n_entries;
  logic [7:0]  name_mem [256];
  int unsigned name_len;
  int unsigned pat_fill;
  bit          too_long;
  logic [9:0]  answers [$];
  int          n_errors;

  function new();
    n_entries = 0;
    name_len  = 0;
    pat_fill  = 0;
    too_long  = 0;
    n_errors  = 0;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic bit tail_match(int unsigned dlen, int unsigned e, int unsigned off,
                                    int unsigned n);
    if (n > dlen) begin
      return 0;
    end
    for (int unsigned k = 0; k < n; k++) begin
      if (name_mem[dlen - n + k] !== pat_mem[e][off + k]) begin
        return 0;
      end
    end
    return 1;
  endfunction

  // Returns the index of the first matching entry, or -1.
  function automatic int first_hit(int unsigned dlen);
    int unsigned flen;
    for (int unsigned i = 0; i < n_entries; i++) begin
      flen = pat_len[i];
      if (flen == 0) begin
        continue;
      end
      if (pat_mem[i][0] == dbm_pkg::ChStar) begin
        if (tail_match(dlen, i, 1, flen - 1)) begin
          return i;
        end
      end else begin
        if (dlen == flen && tail_match(dlen, i, 0, flen)) begin
          return i;
        end
        if (dlen > flen + 1 && name_mem[dlen - flen - 1] == dbm_pkg::ChDot &&
            tail_match(dlen, i, 0, flen)) begin
          return i;
        end
      end
    end
    return -1;
  endfunction

  // Notes one accepted input beat.
  function void note_beat(logic [1:0] cmd, logic [7:0] raw, bit has, bit lst);
    logic [7:0]  c;
    logic        blk;
    logic [5:0]  idx;
    logic [1:0]  st;
    bit          full;
    int          hit;
    int unsigned dlen;
    c   = lower(raw);
    blk = 0;
    idx = 0;
    st  = dbm_pkg::StOk;
    if (cmd == dbm_pkg::CmdClear) begin
      n_entries = 0;
      name_len  = 0;
      pat_fill  = 0;
      too_long  = 0;
      answers.push_back(10'd0);
    end else if (cmd == dbm_pkg::CmdLoad) begin
      full = (n_entries >= 64);
      if (has) begin
        if (pat_fill < 255) begin
          if (!full) begin
            pat_mem[n_entries][pat_fill] = c;
          end
          pat_fill++;
        end else begin
          too_long = 1;
        end
      end
      if (lst) begin
        if (full) begin
          st = dbm_pkg::StFull;
        end else if (too_long) begin
          st = dbm_pkg::StLong;
        end else if (pat_fill == 0 || pat_mem[n_entries][0] == dbm_pkg::ChHash) begin
          st = dbm_pkg::StSkip;
        end else begin
          pat_len[n_entries] = pat_fill[7:0];
          n_entries++;
        end
        pat_fill = 0;
        too_long = 0;
        answers.push_back({1'b0, st, 6'd0, 1'b0});
      end
    end else if (cmd == dbm_pkg::CmdQuery) begin
      if (has) begin
        if (name_len < 255) begin
          name_mem[name_len] = c;
          name_len++;
        end else begin
          too_long = 1;
        end
      end
      if (lst) begin
        if (too_long) begin
          st = dbm_pkg::StLong;
        end else begin
          dlen = name_len;
          if (dlen > 0 && name_mem[dlen - 1] == dbm_pkg::ChDot) begin
            dlen--;
          end
          hit = first_hit(dlen);
          if (hit >= 0) begin
            blk = 1;
            idx = hit[5:0];
          end
        end
        name_len = 0;
        too_long = 0;
        answers.push_back({1'b1, st, idx, blk});
      end
    end
  endfunction

  // Checks one accepted result beat against the oldest pending answer.
  function void check_result(logic [15:0] d);
    logic [9:0] e;
    if (answers.size() == 0) begin
      $error("unexpected result beat 0x%h", d);
      n_errors++;
      return;
    end
    e = answers.pop_front();
    if (d[0] !== e[0]) begin
      $error("blocked: expected %0d, got %0d", e[0], d[0]);
      n_errors++;
    end
    if (d[6:1] !== e[6:1]) begin
      $error("match_index: expected %0d, got %0d", e[6:1], d[6:1]);
      n_errors++;
    end
    if (d[8:7] !== e[8:7]) begin
      $error("status: expected %0d, got %0d", e[8:7], d[8:7]);
      n_errors++;
    end
    if (d[9] !== e[9]) begin
      $error("was_query: expected %0d, got %0d", e[9], d[9]);
      n_errors++;
    end
    if (d[15:10] !== 6'd0) begin
      $error("padding: expected 0, got 0x%h", d[15:10]);
      n_errors++;
    end
  endfunction
endclass

module tb_top;
  import dbm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  domain_blocklist_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  blocklist_oracle oracle = new();

  // Beats sent so far; the stimulus stops a little past the target count.
  int  beats_sent;
  // Burst shaping for the sender: remaining beats in this burst.
  int  burst_left;
  // The receiver's long hold-off runs once it is armed by the stimulus.
  bit  hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: accept whatever the block presents while out_tready is high.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      oracle.check_result(out_tdata);
    end
  end

  // Receiver stall pattern: random stalls at varying rates, occasionally a
  // stretch of full readiness, and one long hold-off on request so the block
  // backs up and has to stall its input while the sender keeps offering beats.
  initial begin
    int mode;
    int n;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end
      mode = $urandom_range(0, 3);
      n = $urandom_range(1, 40);
      repeat (n) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Sends one beat, honoring the burst/gap pattern, and waits for acceptance.
  // The oracle is updated at the edge where the handshake completes.
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] ch, input bit has,
                           input bit lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, has, ch};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    oracle.note_beat(cmd, ch, has, lst);
    beats_sent++;
  endtask

  // Drops the valid line once the stimulus is done.
  task automatic idle_input();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  // Sends a whole string; an empty string is ended by a beat with no byte.
  task automatic send_string(input logic [1:0] cmd, input string s);
    if (s.len() == 0) begin
      send_beat(cmd, 8'h00, 0, 1);
      return;
    end
    for (int k = 0; k < s.len(); k++) begin
      send_beat(cmd, s[k], 1, k == s.len() - 1);
    end
  endtask

  // Random label from a small alphabet so that patterns and names often overlap.
  function automatic string rand_label();
    string s;
    byte   alpha [8] = '{"a", "b", "C", "d", "A", "x", "B", "-"};
    int    n;
    s = "";
    n = $urandom_range(1, 3);
    for (int k = 0; k < n; k++) begin
      s = {s, string'(alpha[$urandom_range(0, 7)])};
    end
    return s;
  endfunction

  function automatic string rand_domain(int labels);
    string s;
    s = rand_label();
    for (int k = 1; k < labels; k++) begin
      s = {s, ".", rand_label()};
    end
    return s;
  endfunction

  // A string of n random bytes with values from 1 to 255.
  function automatic string rand_bytes(int n);
    string s;
    byte   b;
    s = "";
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom_range(1, 255));
      s = {s, string'(b)};
    end
    return s;
  endfunction

  initial begin
    string s;
    int    pick;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CmdLoad;
    in_tlast   = 1'b0;
    rst_n      = 1'b0;
    beats_sent = 0;
    burst_left = 0;
    hold_req   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a query against an empty table, a wildcard, a plain
    // entry, case folding, the trailing dot, a dot at the name's first byte,
    // skipped patterns, the unused command and a bare beat without a byte.
    send_string(CmdQuery, "a.b");
    send_string(CmdLoad, "*.Ab");
    send_string(CmdLoad, "cd");
    send_string(CmdLoad, "#x");
    send_string(CmdLoad, "");
    send_string(CmdQuery, "X.AB.");
    send_string(CmdQuery, ".cd");
    send_string(CmdQuery, "CD");
    send_beat(CmdSpare, 8'hFF, 1, 1);
    send_beat(CmdQuery, 8'h00, 0, 0);
    send_beat(CmdQuery, 8'h80, 1, 1);
    send_beat(CmdLoad, 8'h7F, 1, 0);
    send_beat(CmdQuery, 8'h2E, 1, 1);
    send_beat(CmdLoad, 8'h00, 0, 1);
    send_beat(CmdClear, 8'h00, 0, 0);
    send_string(CmdQuery, "cd");

    // Over-long pattern and name, sent one after the other; they share the overflow flag.
    send_string(CmdLoad, rand_bytes(257));
    send_string(CmdQuery, rand_bytes(256));
    send_string(CmdQuery, {rand_bytes(254), "."});

    // Fill the table past its capacity, then query a few names.
    hold_req = 1;
    for (int k = 0; k < 70; k++) begin
      send_string(CmdLoad, (k % 5 == 0) ? {"*", rand_domain(1)} : rand_domain(1));
    end
    for (int k = 0; k < 10; k++) begin
      send_string(CmdQuery, rand_domain($urandom_range(1, 4)));
    end
    send_beat(CmdClear, 8'h00, 0, 1);

    // Random part: mostly well-formed loads and queries over a small alphabet,
    // with some noise, broken strings and clears.
    while (beats_sent < 1150) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        s = rand_domain($urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) != 0) begin
            s = {".", s};
          end
          s = {"*", s};
        end
        send_string(CmdLoad, s);
      end else if (pick < 80) begin
        s = rand_domain($urandom_range(1, 4));
        if ($urandom_range(0, 4) == 0) begin
          s = {s, "."};
        end
        send_string(CmdQuery, s);
      end else if (pick < 88) begin
        send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        send_string(2'($urandom_range(0, 1)), rand_bytes($urandom_range(0, 6)));
      end else if (pick < 97) begin
        send_beat(CmdClear, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_string(2'($urandom_range(0, 1)), {"#", rand_label()});
      end
    end
    idle_input();

    // Drain: wait for every pending answer, then keep watching for stray results.
    while (oracle.answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);
    if (oracle.n_errors == 0 && oracle.answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

>>> domain_blocklist_matcher.f
rtl/core/dbm_pkg.sv
rtl/core/dbm_cell.sv
rtl/core/domain_blocklist_matcher.sv
test/tb_top.sv
